// ===== hdl/fasta_pattern_search_macros.svh =====
// Assertion macros shared by the FASTA pattern search design.
`ifndef FASTA_PATTERN_SEARCH_MACROS_SVH
`define FASTA_PATTERN_SEARCH_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fps_pkg.sv =====
// Package with shared constants, types and functions of the FASTA pattern search.
package fps_pkg;

   // Default sizes.
   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int OFFSET_BITS_DEFAULT = 32;

   // Number of pattern characters held in the configuration registers.
   localparam int REG_CHARS = 32;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [2:0] CSR_CHARS_0        = 3'd1;
   localparam logic [2:0] CSR_CHARS_1        = 3'd2;
   localparam logic [2:0] CSR_CHARS_2        = 3'd3;
   localparam logic [2:0] CSR_CHARS_3        = 3'd4;

   // Character codes.
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;
   localparam logic [7:0] CHAR_U       = 8'd85;
   localparam logic [7:0] CHAR_T       = 8'd84;
   localparam logic [7:0] CHAR_GT      = 8'd62;
   localparam logic [7:0] CHAR_NL      = 8'd10;
   localparam logic [7:0] CHAR_NUL     = 8'd0;

   // Control handed from the top level to each cell of the candidate chain.
   typedef struct packed {
      logic clear;
      logic shift;
      logic nl_load;
   } cell_ctrl_type;

   // Folds lower case to upper case and then U to T.
   function automatic logic [7:0] clean_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) begin
         r = b - CASE_OFFSET;
      end
      if (r == CHAR_U) begin
         r = CHAR_T;
      end
      return r;
   endfunction

endpackage

// ===== hdl/fasta_pattern_search.sv =====
// Top level of the FASTA pattern search: stream control, candidate chain and result register.
//
// The block takes one FASTA text byte per cycle while req_stall is low. The
// result for the byte that completes the first match, or for the zero byte that
// ends an unmatched text, is registered in the output stage with the match start
// and the start of the current record. A zero byte also clears the search. A
// chain of PATTERN_MAX-1 cells, each holding one partial match, updates in
// parallel on every transfer, so the block sustains one byte per cycle. Results
// leave through a two-entry output stage, and the input stalls only while two
// results wait there, one in the output register and one behind it. No clearing
// pass follows reset.
module fasta_pattern_search #(
   parameter int PATTERN_MAX = fps_pkg::PATTERN_MAX_DEFAULT,
   parameter int OFFSET_BITS = fps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_sequence_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_match_offset,
   output logic [31:0] rsp_record_offset,
   output logic        rsp_record_known
);

`include "fasta_pattern_search_macros.svh"

   localparam int LEN_W = ($clog2(PATTERN_MAX + 1) > 6) ? $clog2(PATTERN_MAX + 1) : 6;

   // Configuration registers.
   logic [5:0]                         pattern_length_ff;
   logic [fps_pkg::REG_CHARS*8-1:0]    pattern_chars_ff;

   // Stream state.
   logic                   in_header_ff,    in_header_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff,  byte_offset_in;
   logic [OFFSET_BITS-1:0] record_start_ff, record_start_in;
   logic                   record_seen_ff,  record_seen_in;
   logic                   search_done_ff,  search_done_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff,     found_in;
   logic [31:0] match_ff,     match_in;
   logic [31:0] record_ff,    record_in;
   logic        known_ff,     known_in;

   // Second result entry, waiting behind the output register.
   logic        skid_valid_ff,  skid_valid_in;
   logic        skid_found_ff,  skid_found_in;
   logic [31:0] skid_match_ff,  skid_match_in;
   logic [31:0] skid_record_ff, skid_record_in;
   logic        skid_known_ff,  skid_known_in;

   // Result produced by the current transfer.
   logic        res_valid;
   logic        res_found;
   logic [31:0] res_match;
   logic [31:0] res_record;
   logic        res_known;
   logic        head_free;

   logic                   accept;
   logic [7:0]             text_char;
   logic                   is_zero;
   logic                   is_nl;
   logic                   is_gt;
   logic [LEN_W-1:0]       len_wide;
   logic [LEN_W-1:0]       len_eff;
   logic                   len_zero;
   logic                   step;
   logic                   clear_cands;
   logic                   hit;
   logic [OFFSET_BITS-1:0] hit_start;
   logic [OFFSET_BITS-1:0] next_offset;
   logic [OFFSET_BITS+31:0] match_wide;
   logic [OFFSET_BITS+31:0] record_wide;

   logic [7:0]             pch         [PATTERN_MAX];
   logic                   adv         [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] start_chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hit_vec;

   // Conditions checked by the assertions.
   logic rsp_notfound_ok;
   logic rsp_record_ok;
   logic search_cleared;

   // A byte is taken unless two finished results already wait downstream.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign text_char = fps_pkg::clean_byte(req_sequence_byte);
   assign is_zero   = (req_sequence_byte == fps_pkg::CHAR_NUL);
   assign is_nl     = (req_sequence_byte == fps_pkg::CHAR_NL);
   assign is_gt     = (req_sequence_byte == fps_pkg::CHAR_GT);

   // Pattern length, saturated to the chain length.
   assign len_wide = LEN_W'(pattern_length_ff);
   assign len_eff  = (len_wide > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_wide;
   assign len_zero = (len_eff == '0);

   // A sequence byte that takes part in matching.
   assign step = accept && !search_done_ff && !len_zero && !is_zero && !in_header_ff && !is_gt;

   // Any zero byte ends the text; a header opener drops all candidates.
   assign clear_cands = accept && (is_zero ||
                        (!search_done_ff && !len_zero && !in_header_ff && is_gt));

   assign next_offset = byte_offset_ff + OFFSET_BITS'(1);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_chars_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            fps_pkg::CSR_PATTERN_LENGTH: pattern_length_ff        <= csr_write_data[5:0];
            fps_pkg::CSR_CHARS_0:        pattern_chars_ff[63:0]    <= csr_write_data;
            fps_pkg::CSR_CHARS_1:        pattern_chars_ff[127:64]  <= csr_write_data;
            fps_pkg::CSR_CHARS_2:        pattern_chars_ff[191:128] <= csr_write_data;
            fps_pkg::CSR_CHARS_3:        pattern_chars_ff[255:192] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Cleaned pattern characters; positions beyond the registers never match.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pch
      if (k < fps_pkg::REG_CHARS) begin : g_reg
         assign pch[k] = fps_pkg::clean_byte(pattern_chars_ff[8*k +: 8]);
      end else begin : g_none
         assign pch[k] = fps_pkg::CHAR_NUL;
      end
   end

   // The head of the chain is a candidate that starts at the current byte.
   assign adv[0]         = (pch[0] == text_char);
   assign start_chain[0] = byte_offset_ff;

   // Candidate chain.
   for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_cell
      fps_pkg::cell_ctrl_type ctrl;

      assign ctrl.clear   = clear_cands;
      assign ctrl.shift   = step && !is_nl && (LEN_W'(k) < len_eff);
      assign ctrl.nl_load = step && is_nl && (k == 1) && (LEN_W'(k) < len_eff);

      fps_cell #(
         .OFFSET_BITS (OFFSET_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .adv_in       (adv[k-1]),
         .start_in     (start_chain[k-1]),
         .pattern_char (pch[k]),
         .text_char    (text_char),
         .adv_out      (adv[k]),
         .start_out    (start_chain[k])
      );
   end

   // The cell at the last pattern position completes the match.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_hit
      assign hit_vec[k] = adv[k] && (len_eff == LEN_W'(k + 1)) && ((k == 0) || !is_nl);
   end

   assign hit = step && (|hit_vec);

   always_comb begin
      hit_start = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (hit_vec[k]) begin
            hit_start = hit_start | start_chain[k];
         end
      end
   end

   // Offsets are reported in 32 bits.
   assign match_wide  = {32'd0, hit_start};
   assign record_wide = {32'd0, record_start_ff};

   // Stream state and result selection for one transfer.
   always_comb begin
      in_header_in    = in_header_ff;
      byte_offset_in  = byte_offset_ff;
      record_start_in = record_start_ff;
      record_seen_in  = record_seen_ff;
      search_done_in  = search_done_ff;
      res_valid       = 1'b0;
      res_found       = 1'b0;
      res_match       = '0;
      res_record      = '0;
      res_known       = 1'b0;
      if (accept) begin
         if (search_done_ff) begin
            if (is_zero) begin
               in_header_in    = 1'b0;
               byte_offset_in  = '0;
               record_start_in = '0;
               record_seen_in  = 1'b0;
               search_done_in  = 1'b0;
            end
         end else if (len_zero) begin
            res_valid      = 1'b1;
            res_found      = 1'b1;
            record_seen_in = 1'b0;
            if (is_zero) begin
               in_header_in    = 1'b0;
               byte_offset_in  = '0;
               record_start_in = '0;
               search_done_in  = 1'b0;
            end else begin
               search_done_in = 1'b1;
            end
         end else if (is_zero) begin
            res_valid       = 1'b1;
            in_header_in    = 1'b0;
            byte_offset_in  = '0;
            record_start_in = '0;
            record_seen_in  = 1'b0;
            search_done_in  = 1'b0;
         end else begin
            byte_offset_in = next_offset;
            if (in_header_ff) begin
               if (is_nl) begin
                  in_header_in    = 1'b0;
                  record_start_in = next_offset;
                  record_seen_in  = 1'b1;
               end
            end else if (is_gt) begin
               in_header_in = 1'b1;
            end else if (hit) begin
               search_done_in = 1'b1;
               res_valid      = 1'b1;
               res_found      = 1'b1;
               res_match      = match_wide[31:0];
               res_record     = record_seen_ff ? record_wide[31:0] : 32'd0;
               res_known      = record_seen_ff;
            end
         end
      end
   end

   // Output stage: the waiting entry moves up first, a new result fills the free place.
   assign head_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      found_in       = found_ff;
      match_in       = match_ff;
      record_in      = record_ff;
      known_in       = known_ff;
      skid_valid_in  = skid_valid_ff;
      skid_found_in  = skid_found_ff;
      skid_match_in  = skid_match_ff;
      skid_record_in = skid_record_ff;
      skid_known_in  = skid_known_ff;
      if (head_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            found_in      = skid_found_ff;
            match_in      = skid_match_ff;
            record_in     = skid_record_ff;
            known_in      = skid_known_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = res_valid;
            found_in     = res_found;
            match_in     = res_match;
            record_in    = res_record;
            known_in     = res_known;
         end
      end else if (res_valid) begin
         skid_valid_in  = 1'b1;
         skid_found_in  = res_found;
         skid_match_in  = res_match;
         skid_record_in = res_record;
         skid_known_in  = res_known;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff    <= 1'b0;
         byte_offset_ff  <= '0;
         record_start_ff <= '0;
         record_seen_ff  <= 1'b0;
         search_done_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         in_header_ff    <= in_header_in;
         byte_offset_ff  <= byte_offset_in;
         record_start_ff <= record_start_in;
         record_seen_ff  <= record_seen_in;
         search_done_ff  <= search_done_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff       <= found_in;
      match_ff       <= match_in;
      record_ff      <= record_in;
      known_ff       <= known_in;
      skid_found_ff  <= skid_found_in;
      skid_match_ff  <= skid_match_in;
      skid_record_ff <= skid_record_in;
      skid_known_ff  <= skid_known_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_offset  = match_ff;
   assign rsp_record_offset = record_ff;
   assign rsp_record_known  = known_ff;

   assign rsp_notfound_ok = found_ff || ((match_ff == 32'd0) && !known_ff);
   assign rsp_record_ok   = known_ff || (record_ff == 32'd0);
   assign search_cleared  = (byte_offset_ff == '0) && !search_done_ff && !in_header_ff &&
                            !record_seen_ff;

   // A not-found result carries no offsets.
   `FPS_ASSERT_NOW(a_notfound_zero, rsp_valid_ff, rsp_notfound_ok, "offset in a not-found result")

   // A record offset is only given with a known record.
   `FPS_ASSERT_NOW(a_record_known, rsp_valid_ff, rsp_record_ok, "record offset without a record")

   // A second result only ever waits behind a first one.
   `FPS_ASSERT_NOW(a_skid_order, skid_valid_ff, rsp_valid_ff, "second result without a first")

   // A zero byte leaves the search cleared.
   `FPS_ASSERT_NEXT(a_zero_clears, accept && is_zero, search_cleared, "search not cleared")

   // A completed match ends the search and leaves a result waiting.
   `FPS_ASSERT_NEXT(a_hit_done, hit, search_done_ff && rsp_valid_ff, "match did not end search")

endmodule

// ===== hdl/fps_cell.sv =====
// One cell of the candidate chain: holds a partial match and its start offset.
module fps_cell #(
   parameter int OFFSET_BITS = fps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fps_pkg::cell_ctrl_type    ctrl,
   input  logic                      adv_in,
   input  logic [OFFSET_BITS-1:0]    start_in,
   input  logic [7:0]                pattern_char,
   input  logic [7:0]                text_char,
   output logic                      adv_out,
   output logic [OFFSET_BITS-1:0]    start_out
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [OFFSET_BITS-1:0] start_ff;
   logic [OFFSET_BITS-1:0] start_in_sel;
   logic                   nl_take;

   // A newline may only open a candidate in an empty first cell.
   assign nl_take = ctrl.nl_load && adv_in && !valid_ff;

   // Next candidate state.
   always_comb begin
      valid_in     = valid_ff;
      start_in_sel = start_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in     = adv_in;
         start_in_sel = start_in;
      end else if (nl_take) begin
         valid_in     = 1'b1;
         start_in_sel = start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in_sel;
   end

   // The candidate advances when its next pattern character matches the text.
   assign adv_out   = valid_ff && (pattern_char == text_char);
   assign start_out = start_ff;

endmodule

// ===== tb/fasta_pattern_search_tb.sv =====
// Self-checking testbench for the FASTA pattern search block.
`timescale 1ns / 1ps

// One result transfer as seen on the rsp_ ports.
typedef struct packed {
   logic        found;
   logic [31:0] match_offset;
   logic [31:0] record_offset;
   logic        record_known;
} match_result_type;

// Tracks the search state of the block, predicts its results and checks them.
class match_tracker;
   localparam int CAP = 32;

   logic [5:0]       len_reg;
   logic [63:0]      char_regs [0:3];
   bit               cand_valid [0:CAP];
   logic [31:0]      cand_start [0:CAP];
   bit               in_header;
   bit               record_seen;
   bit               search_done;
   logic [31:0]      byte_offset;
   logic [31:0]      record_start;
   match_result_type expected_matches [$];
   int               mismatches;
   int               results_expected;

   function new();
      len_reg = '0;
      foreach (char_regs[i]) char_regs[i] = '0;
      clear_text();
      mismatches = 0;
      results_expected = 0;
   endfunction

   function void clear_text();
      foreach (cand_valid[i]) begin
         cand_valid[i] = 1'b0;
         cand_start[i] = '0;
      end
      in_header = 1'b0;
      record_seen = 1'b0;
      search_done = 1'b0;
      byte_offset = '0;
      record_start = '0;
   endfunction

   function void write_reg(logic [2:0] index, logic [63:0] value);
      case (index)
         fps_pkg::CSR_PATTERN_LENGTH: len_reg = value[5:0];
         fps_pkg::CSR_CHARS_0:        char_regs[0] = value;
         fps_pkg::CSR_CHARS_1:        char_regs[1] = value;
         fps_pkg::CSR_CHARS_2:        char_regs[2] = value;
         fps_pkg::CSR_CHARS_3:        char_regs[3] = value;
         default: ;
      endcase
   endfunction

   // Lower-case letters all have the case bit set, so clearing it gives upper case.
   function logic [7:0] fold_char(logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (r >= fps_pkg::CHAR_LOWER_A && r <= fps_pkg::CHAR_LOWER_Z)
         r = r & ~fps_pkg::CASE_OFFSET;
      if (r == fps_pkg::CHAR_U) r = fps_pkg::CHAR_T;
      return r;
   endfunction

   function logic [7:0] pattern_char(int k);
      return fold_char(char_regs[k >> 3][8 * (k & 7) +: 8]);
   endfunction

   function void post(bit hit, logic [31:0] start);
      match_result_type r;
      r.found         = hit;
      r.match_offset  = hit ? start : '0;
      r.record_offset = (hit && record_seen) ? record_start : '0;
      r.record_known  = hit && record_seen;
      expected_matches.push_back(r);
      results_expected++;
   endfunction

   // Advances the search by one accepted text byte.
   function void take_byte(logic [7:0] b);
      int          len;
      int          k;
      logic [7:0]  c;
      logic [31:0] here;
      logic [31:0] start;
      bit          hit;
      bit          adv;
      len = (len_reg > CAP) ? CAP : len_reg;
      here = byte_offset;
      hit = 1'b0;
      start = '0;
      // Once matched, bytes are ignored until the text ends.
      if (search_done) begin
         if (b == fps_pkg::CHAR_NUL) clear_text();
         return;
      end
      // An empty pattern matches at once at offset zero.
      if (len == 0) begin
         record_seen = 1'b0;
         post(1'b1, '0);
         if (b == fps_pkg::CHAR_NUL) clear_text();
         else search_done = 1'b1;
         return;
      end
      if (b == fps_pkg::CHAR_NUL) begin
         post(1'b0, '0);
         clear_text();
         return;
      end
      byte_offset = byte_offset + 1;
      // Header lines run up to their newline and never take part in a match.
      if (in_header) begin
         if (b == fps_pkg::CHAR_NL) begin
            in_header = 1'b0;
            record_start = byte_offset;
            record_seen = 1'b1;
         end
         return;
      end
      if (b == fps_pkg::CHAR_GT) begin
         in_header = 1'b1;
         foreach (cand_valid[i]) cand_valid[i] = 1'b0;
         return;
      end
      c = fold_char(b);
      if (b == fps_pkg::CHAR_NL) begin
         // Candidates hold over a newline; it can only open a new one.
         if (pattern_char(0) == c) begin
            if (len == 1) begin
               hit = 1'b1;
               start = here;
            end else if (!cand_valid[1]) begin
               cand_valid[1] = 1'b1;
               cand_start[1] = here;
            end
         end
      end else begin
         for (k = len - 1; k >= 1; k--) begin
            adv = cand_valid[k] && (pattern_char(k) == c);
            if (k + 1 == len) begin
               if (adv) begin
                  hit = 1'b1;
                  start = cand_start[k];
               end
            end else begin
               cand_valid[k + 1] = adv;
               cand_start[k + 1] = cand_start[k];
            end
         end
         if (pattern_char(0) == c) begin
            if (len == 1) begin
               hit = 1'b1;
               start = here;
            end else begin
               cand_valid[1] = 1'b1;
               cand_start[1] = here;
            end
         end else if (len > 1) begin
            cand_valid[1] = 1'b0;
         end
      end
      if (hit) begin
         search_done = 1'b1;
         post(1'b1, start);
      end
   endfunction

   function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
   endfunction

   // Compares a result transfer with the oldest outstanding prediction.
   function void check_match(match_result_type got);
      match_result_type want;
      if (expected_matches.size() == 0) begin
         report($sformatf("unexpected result found=%0d match=%0d record=%0d known=%0d",
                          got.found, got.match_offset, got.record_offset, got.record_known));
         return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found || got.match_offset !== want.match_offset ||
          got.record_offset !== want.record_offset || got.record_known !== want.record_known)
         report($sformatf({"expected found=%0d match=%0d record=%0d known=%0d, ",
                           "got found=%0d match=%0d record=%0d known=%0d"},
                          want.found, want.match_offset, want.record_offset, want.record_known,
                          got.found, got.match_offset, got.record_offset, got.record_known));
   endfunction

   function int pending();
      return expected_matches.size();
   endfunction
endclass

module fasta_pattern_search_tb;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PATTERN_CAP = 32;
   localparam int RANDOM_BYTES = 1100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = fps_pkg::CSR_PATTERN_LENGTH;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_sequence_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_match_offset;
   logic [31:0] rsp_record_offset;
   logic        rsp_record_known;

   match_tracker tracker = new();

   int          bytes_sent = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;
   bit          hold_go = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          free_left = 0;
   logic [7:0]  pat [0:31];
   int          pat_len = 0;
   bit          pat_plain = 1'b0;

   fasta_pattern_search dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sequence_byte (req_sequence_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_record_offset (rsp_record_offset),
      .rsp_record_known  (rsp_record_known)
   );

   always #5 clock = ~clock;

   // Observes transfers on both channels and ends the run if traffic stops.
   always @(posedge clock) begin : observe
      match_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_byte(req_sequence_byte);
         if (rsp_valid && !rsp_stall) begin
            got.found         = rsp_found;
            got.match_offset  = rsp_match_offset;
            got.record_offset = rsp_record_offset;
            got.record_known  = rsp_record_known;
            tracker.check_match(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Result side: random back-pressure, free-running stretches and one long hold on request.
   always @(negedge clock) begin : rsp_side
      int r;
      if (hold_go && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_go = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            free_left = $urandom_range(0, 4);
            rsp_stall <= 1'b0;
         end else if (r < 85) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else if (r < 93) begin
            stall_left = $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end else begin
            free_left = $urandom_range(30, 120);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [7:0] base_letter();
      string bases;
      bases = "ACGTUNacgtun";
      return bases[$urandom_range(0, bases.len() - 1)];
   endfunction

   // Pattern register bytes beyond the length in use: often all zeros or all ones.
   function automatic logic [7:0] fill_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 8'h00;
      if (r < 40) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 0;
      if (r < 12) return PATTERN_CAP;
      if (r < 16) return $urandom_range(PATTERN_CAP + 1, 63);
      if (r < 24) return $urandom_range(7, PATTERN_CAP - 1);
      return $urandom_range(1, 6);
   endfunction

   // Writes a pattern character in a form that folds to the same character.
   function automatic logic [7:0] respell(input logic [7:0] p);
      logic [7:0] u;
      u = p;
      if ((p >= "A" && p <= "Z") ||
          (p >= fps_pkg::CHAR_LOWER_A && p <= fps_pkg::CHAR_LOWER_Z)) begin
         u = p & ~fps_pkg::CASE_OFFSET;
         if (u == fps_pkg::CHAR_T || u == fps_pkg::CHAR_U)
            u = $urandom_range(0, 1) ? fps_pkg::CHAR_T : fps_pkg::CHAR_U;
         if ($urandom_range(0, 1)) u = u | fps_pkg::CASE_OFFSET;
      end
      return u;
   endfunction

   // Offers one byte and waits for its transfer, then leaves a random gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_sequence_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops offering and waits until every predicted result has been transferred.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      tracker.write_reg(index, value);
      @(negedge clock);
   endtask

   // Chooses a pattern and writes every register; a negative length picks one at random.
   task automatic new_pattern(input int len_pick);
      logic [63:0] word;
      int          len_code;
      int          r;
      int          i;
      int          k;
      len_code = (len_pick >= 0) ? len_pick : pick_length();
      pat_len = (len_code > PATTERN_CAP) ? PATTERN_CAP : len_code;
      pat_plain = 1'b1;
      for (k = 0; k < 32; k++) pat[k] = (k < pat_len) ? base_letter() : fill_byte();
      r = $urandom_range(0, 99);
      if (pat_len > 0) begin
         if (r < 4) begin
            // Arbitrary bytes, which the text will hardly ever reproduce.
            for (k = 0; k < pat_len; k++) pat[k] = 8'($urandom_range(0, 255));
            pat_plain = 1'b0;
         end else if (r < 10) begin
            pat[0] = fps_pkg::CHAR_NL;
         end else if (r < 14) begin
            pat[$urandom_range(0, pat_len - 1)] = fps_pkg::CHAR_NUL;
            pat_plain = 1'b0;
         end
      end
      word = $urandom_range(0, 1) ? {$urandom(), $urandom()} : 64'd0;
      word[5:0] = len_code[5:0];
      csr_write(fps_pkg::CSR_PATTERN_LENGTH, word);
      for (i = 0; i < 4; i++) begin
         for (k = 0; k < 8; k++) word[8 * k +: 8] = pat[8 * i + k];
         csr_write(fps_pkg::CSR_CHARS_0 + 3'(i), word);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_header();
      int n;
      int k;
      send_byte(fps_pkg::CHAR_GT);
      n = $urandom_range(0, 8);
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(1, 255)));
      send_byte(fps_pkg::CHAR_NL);
   endtask

   // Sends the current pattern respelled, with newlines now and then inside it.
   task automatic send_planted();
      int k;
      for (k = 0; k < pat_len; k++) begin
         if (k > 0 && $urandom_range(0, 5) == 0) send_byte(fps_pkg::CHAR_NL);
         send_byte(respell(pat[k]));
      end
   endtask

   // One FASTA text of one or two records, mostly closed by a zero byte.
   task automatic send_text();
      int recs;
      int lines;
      int n;
      int r;
      int rec;
      int line;
      int j;
      int plant_rec;
      int plant_line;
      recs = $urandom_range(1, 2);
      plant_rec = (pat_plain && pat_len > 0) ? $urandom_range(0, recs) : recs;
      for (rec = 0; rec < recs; rec++) begin
         if ($urandom_range(0, 3) != 0) send_header();
         lines = $urandom_range(1, 3);
         plant_line = $urandom_range(0, lines - 1);
         for (line = 0; line < lines; line++) begin
            n = $urandom_range(0, 10);
            for (j = 0; j < n; j++) begin
               if (rec == plant_rec && line == plant_line && j == n / 2) send_planted();
               r = $urandom_range(0, 99);
               if (r < 90) send_byte(base_letter());
               else if (r < 92) send_byte(fps_pkg::CHAR_GT);
               else send_byte(8'($urandom_range(1, 255)));
            end
            send_byte(fps_pkg::CHAR_NL);
         end
      end
      if ($urandom_range(0, 19) != 0) send_byte(fps_pkg::CHAR_NUL);
   endtask

   // Short opening: empty pattern, a match across a newline after a header, a match
   // after a stray header mark, bytes after a match, and texts that end unmatched.
   task automatic send_opening();
      logic [7:0] text [$];
      // The reset pattern is empty: a hit at once, then a clear, then a hit on zero.
      send_byte("A");
      send_byte(fps_pkg::CHAR_NUL);
      send_byte(fps_pkg::CHAR_NUL);
      settle();
      csr_write(fps_pkg::CSR_PATTERN_LENGTH, 64'd3);
      csr_write(fps_pkg::CSR_CHARS_0, 64'h800A3E00FF556341);
      csr_write(fps_pkg::CSR_CHARS_1, 64'd0);
      csr_write(fps_pkg::CSR_CHARS_2, 64'hFFFFFFFFFFFFFFFF);
      csr_write(fps_pkg::CSR_CHARS_3, {$urandom(), $urandom()});
      csr_write_enable <= 1'b0;
      text = '{fps_pkg::CHAR_GT, 8'hFF, fps_pkg::CHAR_NL, "g", "a", fps_pkg::CHAR_NL,
               "c", "t", "A", fps_pkg::CHAR_NUL,
               "a", "c", fps_pkg::CHAR_GT, 8'h80, fps_pkg::CHAR_NL, "a", "C", "u",
               fps_pkg::CHAR_NUL,
               fps_pkg::CHAR_NUL, fps_pkg::CHAR_GT, 8'h7F, fps_pkg::CHAR_NUL};
      foreach (text[i]) send_byte(text[i]);
   endtask

   initial begin : stimulus
      int phase;
      int ntexts;
      int random_start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_opening();
      settle();

      // Back-pressure: an empty pattern turns every zero byte into a result while the
      // result side holds off, so the block fills up and stalls its input.
      csr_write(fps_pkg::CSR_PATTERN_LENGTH, 64'd0);
      csr_write_enable <= 1'b0;
      hold_go = 1'b1;
      no_gaps = 1'b1;
      repeat (24) send_byte(fps_pkg::CHAR_NUL);
      no_gaps = 1'b0;

      // Random phases, each with a fresh pattern written while the block is idle.
      random_start = bytes_sent;
      phase = 0;
      while (bytes_sent < random_start + RANDOM_BYTES) begin
         settle();
         case (phase)
            0:       new_pattern(63);
            1:       new_pattern(PATTERN_CAP);
            2:       new_pattern(1);
            3:       new_pattern(0);
            default: new_pattern(-1);
         endcase
         phase++;
         no_gaps = ($urandom_range(0, 3) == 0);
         ntexts = $urandom_range(1, 4);
         repeat (ntexts) send_text();
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
